// ----- hw/rtl/thruster_force_allocator_unit_assert.svh -----
// Assertion macros shared by the allocator checks.
`ifndef THRUSTER_FORCE_ALLOCATOR_UNIT_ASSERT_SVH
`define THRUSTER_FORCE_ALLOCATOR_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define TFA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/tfa_pkg.sv -----
// Shared types and constants of the thruster force allocator.
package tfa_pkg;

	localparam int MAX_THRUSTERS_DEF = 8;
	localparam int WRENCH_DIM        = 6;
	localparam int VAL_W             = 24;
	localparam int CH_MAX            = 8;
	localparam logic [14:0] LEVEL_MAX = 15'd32767;

	// Input word kinds, carried on tuser.
	typedef enum logic [1:0] {
		CMD_LOAD_COEF  = 2'd0,
		CMD_LOAD_SCALE = 2'd1,
		CMD_ALLOCATE   = 2'd2
	} tfa_cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_THRUSTER_COUNT = 2'd0,
		REG_DIRECT_MODE    = 2'd1,
		REG_INV_FORCE      = 2'd2,
		REG_INV_MOMENT     = 2'd3
	} tfa_reg_t;

	// Control that travels with every channel down the pipeline.
	typedef struct packed {
		logic       valid;
		logic [2:0] channel;
		logic       last;
		logic       direct;
		logic       neg;
	} tfa_ctl_t;

	// Operands of one issued channel, read from the matrix and scale memories.
	typedef struct packed {
		logic [VAL_W-1:0]         dmag;
		logic [VAL_W-1:0]         inv;
		logic [5:0][VAL_W-1:0]    w;
		logic [5:0][VAL_W-1:0]    coef;
		logic [VAL_W-1:0]         scale;
	} tfa_issue_t;

endpackage

// ----- hw/rtl/thruster_force_allocator_unit.sv -----
// Top level of the thruster force allocator: registers, memories, sequencer.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tuser command; tdata row, thruster, value, wrench
//  m_*       out  m_tvalid/m_tready  tdata channel and level; tlast on final channel
//  APB       in   psel/penable       four configuration registers at 0x0..0xC
//
// Load words are accepted while the sequencer is idle. An allocate word issues one
// channel at a time (six in direct mode, else the thruster count capped at the smaller
// of MAX_THRUSTERS and CH_MAX), as the sequencer reads one matrix row per cycle from six
// column memories. Results pass the issue registers, the pipe stages and the output
// register. While a word waits at the output with m_tready low, the whole pipeline and
// the sequencer hold. Reset restores the registers; matrix and scales are not cleared.
module thruster_force_allocator_unit #(
	parameter int MAX_THRUSTERS = tfa_pkg::MAX_THRUSTERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [175:0] s_tdata,  // wrench_row, thruster_index, load_value, force_x,
	                               // force_y, force_z, moment_x, moment_y, moment_z, zero
	input  logic [1:0]   s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,  // channel, level, zero
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW  = $clog2(MAX_THRUSTERS);
	localparam int LIM = (MAX_THRUSTERS < tfa_pkg::CH_MAX) ? MAX_THRUSTERS : tfa_pkg::CH_MAX;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_ISSUE = 2'b10
	} seq_state_t;

	// Input word fields.
	logic [2:0]  in_row, in_thr;
	logic [23:0] in_val;
	logic [23:0] in_w [6];
	assign in_row = s_tdata[2:0];
	assign in_thr = s_tdata[5:3];
	assign in_val = s_tdata[29:6];
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			in_w[j] = s_tdata[30 + 24*j +: 24];
		end
	end

	// Configuration registers.
	logic [3:0]  thr_count_q;
	logic        direct_q;
	logic [23:0] inv_force_q, inv_moment_q;
	logic        cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_count_q  <= '0;
			direct_q     <= 1'b0;
			inv_force_q  <= 24'd65536;
			inv_moment_q <= 24'd65536;
		end else if (cfg_wr) begin
			case (tfa_pkg::tfa_reg_t'(paddr[3:2]))
				tfa_pkg::REG_THRUSTER_COUNT: thr_count_q  <= pwdata[3:0];
				tfa_pkg::REG_DIRECT_MODE:    direct_q     <= pwdata[0];
				tfa_pkg::REG_INV_FORCE:      inv_force_q  <= pwdata[23:0];
				tfa_pkg::REG_INV_MOMENT:     inv_moment_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tfa_pkg::tfa_reg_t'(paddr[3:2]))
			tfa_pkg::REG_THRUSTER_COUNT: prdata = {28'd0, thr_count_q};
			tfa_pkg::REG_DIRECT_MODE:    prdata = {31'd0, direct_q};
			tfa_pkg::REG_INV_FORCE:      prdata = {8'd0, inv_force_q};
			tfa_pkg::REG_INV_MOMENT:     prdata = {8'd0, inv_moment_q};
			default:                     prdata = '0;
		endcase
	end

	// Accepted words.
	seq_state_t  state_q;
	logic in_acc, acc_coef, acc_scale, acc_alloc, thr_ok;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign thr_ok    = 32'(in_thr) < MAX_THRUSTERS;
	assign acc_coef  = in_acc && (s_tuser == tfa_pkg::CMD_LOAD_COEF) && thr_ok
		&& (in_row < 3'(tfa_pkg::WRENCH_DIM));
	assign acc_scale = in_acc && (s_tuser == tfa_pkg::CMD_LOAD_SCALE) && thr_ok;
	assign acc_alloc = in_acc && (s_tuser == tfa_pkg::CMD_ALLOCATE);

	// Matrix held as six column memories, one row per cycle unless stalled; scales alongside.
	logic [23:0] mat_mem [6][MAX_THRUSTERS];
	logic [23:0] scale_mem [MAX_THRUSTERS];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			if (acc_coef && (in_row == 3'(j))) begin
				mat_mem[j][AW'(in_thr)] <= in_val;
			end
		end
		if (acc_scale) begin
			scale_mem[AW'(in_thr)] <= in_val[23] ? 24'd0 : in_val;
		end
	end

	// Channel sequencer.
	logic [2:0]  cnt_q;
	logic [3:0]  n_q;
	logic        mode_q;
	logic [23:0] w_q [6];
	logic [3:0]  n_c;
	logic        adv, issue, issue_last;

	always_comb begin
		if (direct_q) begin
			n_c = 4'(tfa_pkg::WRENCH_DIM);
		end else if (thr_count_q > 4'(LIM)) begin
			n_c = 4'(LIM);
		end else begin
			n_c = thr_count_q;
		end
	end

	assign issue      = (state_q == ST_ISSUE) && adv;
	assign issue_last = ({1'b0, cnt_q} + 4'd1) == n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			mode_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_alloc && (n_c != 4'd0)) begin
						state_q <= ST_ISSUE;
						cnt_q   <= '0;
						n_q     <= n_c;
						mode_q  <= direct_q;
					end
				end
				ST_ISSUE: begin
					if (issue) begin
						cnt_q <= cnt_q + 3'd1;
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_alloc) begin
			for (int j = 0; j < 6; j++) begin
				w_q[j] <= in_w[j];
			end
		end
	end

	// Direct mode operand: magnitude of one wrench component.
	logic [23:0] comp_c, dmag_c;
	always_comb begin
		comp_c = w_q[cnt_q];
		dmag_c = comp_c[23] ? (24'd0 - comp_c) : comp_c;
	end

	// First pipeline stage: registered memory reads and operands.
	tfa_pkg::tfa_ctl_t   ctl_s1;
	tfa_pkg::tfa_issue_t iss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: issue, channel: cnt_q, last: issue_last, direct: mode_q,
				neg: mode_q && comp_c[23]};
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			for (int j = 0; j < 6; j++) begin
				iss_s1.w[j]    <= w_q[j];
				iss_s1.coef[j] <= mat_mem[j][AW'(cnt_q)];
			end
			iss_s1.scale <= scale_mem[AW'(cnt_q)];
			iss_s1.dmag  <= dmag_c;
			iss_s1.inv   <= (cnt_q < 3'd3) ? inv_force_q : inv_moment_q;
		end
	end

	tfa_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.iss_s1   (iss_s1),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hw/rtl/tfa_pipe.sv -----
// Arithmetic pipeline: products, adder tree, scaling, rounding and output register.
module tfa_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  tfa_pkg::tfa_ctl_t  ctl_s1,
	input  tfa_pkg::tfa_issue_t iss_s1,
	output logic               adv,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // channel [2:0], level [18:3], zero [23:19]
	output logic               m_tlast
);

	tfa_pkg::tfa_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	tfa_pkg::tfa_ctl_t ctl_c;

	logic signed [47:0] prod_s2 [6];
	logic signed [48:0] pair_s3 [3];
	logic signed [50:0] sum_s4;
	logic        [49:0] mag_s5;
	logic        [48:0] hi_s6, lo_s6;
	logic        [14:0] lv_s7;
	logic        [23:0] scale_s2, scale_s3, scale_s4, scale_s5;
	logic        [47:0] dprod_s2, dprod_s3, dprod_s4, dprod_s5, dprod_s6;

	logic        [2:0]  ch_q;
	logic        [15:0] level_q;
	logic               last_q, valid_q;

	// The whole pipeline moves when the output register is free or being emptied.
	assign adv = !valid_q || m_tready;

	// The sign of an allocation is known only once the sum is complete.
	always_comb begin
		ctl_c     = ctl_s4;
		ctl_c.neg = ctl_s4.direct ? ctl_s4.neg : sum_s4[50];
	end

	// Control bits, with valid cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			ctl_s5     <= ctl_c;
			ctl_s6     <= ctl_s5;
			ctl_s7     <= ctl_s6;
			valid_q    <= ctl_s7.valid;
		end
	end

	// Magnitude of the summed row.
	logic signed [50:0] sum_neg;
	logic        [49:0] mag_c;
	always_comb begin
		sum_neg = -sum_s4;
		mag_c   = sum_s4[50] ? sum_neg[49:0] : sum_s4[49:0];
	end

	// Rounding to Q1.15 with ties away from zero, then the limit.
	logic        [49:0] tot_c, tot_r;
	logic        [20:0] arnd_c;
	logic        [48:0] drnd_full;
	logic        [39:0] drnd_c;
	logic        [14:0] lv_c;
	always_comb begin
		tot_c     = {1'b0, hi_s6[23:0], 25'd0} + {1'b0, lo_s6};
		tot_r     = tot_c + 50'(1) * 50'h0000010000000;
		arnd_c    = tot_r[49:29];
		drnd_full = {1'b0, dprod_s6} + 49'd256;
		drnd_c    = drnd_full[48:9];
		if (ctl_s6.direct) begin
			lv_c = (drnd_c > 40'(tfa_pkg::LEVEL_MAX)) ? tfa_pkg::LEVEL_MAX : drnd_c[14:0];
		end else if (hi_s6[48:24] != '0) begin
			lv_c = tfa_pkg::LEVEL_MAX;
		end else begin
			lv_c = (arnd_c > 21'(tfa_pkg::LEVEL_MAX)) ? tfa_pkg::LEVEL_MAX : arnd_c[14:0];
		end
	end

	// Data path registers; no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				prod_s2[j] <= $signed(iss_s1.w[j]) * $signed(iss_s1.coef[j]);
			end
			dprod_s2 <= iss_s1.dmag * iss_s1.inv;
			scale_s2 <= iss_s1.scale;

			for (int k = 0; k < 3; k++) begin
				pair_s3[k] <= $signed({prod_s2[2*k][47], prod_s2[2*k]})
					+ $signed({prod_s2[2*k+1][47], prod_s2[2*k+1]});
			end
			dprod_s3 <= dprod_s2;
			scale_s3 <= scale_s2;

			sum_s4 <= $signed({{2{pair_s3[0][48]}}, pair_s3[0]})
				+ $signed({{2{pair_s3[1][48]}}, pair_s3[1]})
				+ $signed({{2{pair_s3[2][48]}}, pair_s3[2]});
			dprod_s4 <= dprod_s3;
			scale_s4 <= scale_s3;

			mag_s5   <= mag_c;
			dprod_s5 <= dprod_s4;
			scale_s5 <= scale_s4;

			hi_s6    <= mag_s5[49:25] * scale_s5;
			lo_s6    <= mag_s5[24:0] * scale_s5;
			dprod_s6 <= dprod_s5;

			lv_s7 <= lv_c;

			ch_q    <= ctl_s7.channel;
			last_q  <= ctl_s7.last;
			level_q <= ctl_s7.neg ? (16'd0 - {1'b0, lv_s7}) : {1'b0, lv_s7};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, level_q, ch_q};
	assign m_tlast  = last_q;

endmodule

// ----- hw/rtl/tfa_checker.sv -----
// Port-level checks of the thruster force allocator, bound to the top level.
`include "thruster_force_allocator_unit_assert.svh"

module tfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// Channel expected next: restarts at zero after the final word of a burst.
	logic [2:0] exp_ch_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ch_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_ch_q <= m_tlast ? 3'd0 : (m_tdata[2:0] + 3'd1);
		end
	end

	`TFA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
	`TFA_ASSERT_NEVER(a_no_min, m_tvalid && (m_tdata[18:3] == 16'h8000), "level below minus one")
	`TFA_ASSERT_NEVER(a_pad, m_tvalid && (m_tdata[23:19] != 5'd0), "padding bits not zero")
	`TFA_ASSERT(a_seq, m_tvalid |-> m_tdata[2:0] == exp_ch_q, "channels out of order")
	`TFA_ASSERT(a_top_last, m_tvalid && (m_tdata[2:0] == 3'd7) |-> m_tlast, "channel seven not last")

endmodule

bind thruster_force_allocator_unit tfa_checker u_tfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- verif/thruster_force_allocator_unit_test.sv -----
// Self-checking testbench of the thruster force allocator: stream stimulus, APB setup, level checks.
module thruster_force_allocator_unit_test;

	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
	localparam int         DRAIN_CYCLES = 24;
	localparam int         QUIET_LIMIT  = 3000;

	// One input word: command and the fields carried in tdata.
	typedef struct packed {
		logic [1:0]       command;
		logic [2:0]       row;
		logic [2:0]       thr;
		logic [23:0]      value;
		logic [5:0][23:0] wrench;
	} alloc_word_t;

	// One output word: a channel and its normalised level.
	typedef struct {
		logic [2:0]         channel;
		logic signed [15:0] level;
		logic               last;
	} level_word_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [175:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Predictor state: configuration and the two stores.
	logic [3:0]         cfg_count;
	logic               cfg_direct;
	logic [23:0]        cfg_inv_force;
	logic [23:0]        cfg_inv_moment;
	logic signed [23:0] coef_mem [tfa_pkg::MAX_THRUSTERS_DEF*tfa_pkg::WRENCH_DIM];
	logic [23:0]        scale_mem [tfa_pkg::MAX_THRUSTERS_DEF];

	level_word_t expected_levels [$];

	int  errors;
	int  words_sent;
	int  levels_checked;
	int  reg_writes;
	int  hold_off;
	bit  steady;

	thruster_force_allocator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH: %s", what);
		errors++;
	endtask

	// Round a magnitude with the given fractional bits to Q15 and limit it.
	function automatic logic [14:0] round_level(input logic [127:0] prod, input int frac);
		logic [127:0] r;
		r = (prod + (128'd1 << (frac - 1))) >> frac;
		return (r > 128'd32767) ? tfa_pkg::LEVEL_MAX : r[14:0];
	endfunction

	// Wide-spread signed value: full range down to a few LSBs.
	function automatic logic [23:0] spread_value();
		logic [31:0] r;
		r = $urandom;
		return $signed(r[23:0]) >>> $urandom_range(0, 23);
	endfunction

	function automatic alloc_word_t load_word(input logic [1:0] cmd, input logic [2:0] row,
			input logic [2:0] thr, input logic [23:0] value);
		alloc_word_t wd;
		wd.command = cmd;
		wd.row     = row;
		wd.thr     = thr;
		wd.value   = value;
		for (int i = 0; i < tfa_pkg::WRENCH_DIM; i++)
			wd.wrench[i] = 24'($urandom);
		return wd;
	endfunction

	function automatic alloc_word_t allocate_word(input logic [5:0][23:0] wrench);
		alloc_word_t wd;
		wd = load_word(tfa_pkg::CMD_ALLOCATE, 3'($urandom), 3'($urandom), 24'($urandom));
		wd.wrench = wrench;
		return wd;
	endfunction

	// Update the stores, or work out the levels that an allocate word produces.
	task automatic predict_word(input alloc_word_t wd);
		int                 n;
		logic signed [63:0] acc;
		logic [63:0]        mag;
		logic               neg;
		logic [14:0]        lv;
		logic [23:0]        inv;
		level_word_t        lw;
		case (wd.command)
			tfa_pkg::CMD_LOAD_COEF: begin
				if (wd.row < tfa_pkg::WRENCH_DIM)
					coef_mem[wd.thr*tfa_pkg::WRENCH_DIM + wd.row] = wd.value;
			end
			tfa_pkg::CMD_LOAD_SCALE: begin
				scale_mem[wd.thr] = wd.value[23] ? 24'd0 : wd.value;
			end
			tfa_pkg::CMD_ALLOCATE: begin
				if (cfg_direct) begin
					for (int i = 0; i < tfa_pkg::WRENCH_DIM; i++) begin
						inv = (i < 3) ? cfg_inv_force : cfg_inv_moment;
						acc = longint'($signed(wd.wrench[i]));
						neg = acc < 0;
						mag = neg ? -acc : acc;
						lv  = round_level(128'(mag) * 128'(inv), 9);
						lw.channel = i[2:0];
						lw.level   = neg ? -$signed({1'b0, lv}) : $signed({1'b0, lv});
						lw.last    = (i == tfa_pkg::WRENCH_DIM - 1);
						expected_levels.push_back(lw);
					end
				end else begin
					n = (cfg_count > tfa_pkg::MAX_THRUSTERS_DEF) ?
						tfa_pkg::MAX_THRUSTERS_DEF : int'(cfg_count);
					for (int i = 0; i < n; i++) begin
						acc = 0;
						for (int j = 0; j < tfa_pkg::WRENCH_DIM; j++)
							acc += longint'($signed(wd.wrench[j])) *
								longint'(coef_mem[i*tfa_pkg::WRENCH_DIM + j]);
						neg = acc < 0;
						mag = neg ? -acc : acc;
						lv  = round_level(128'(mag) * 128'(scale_mem[i]), 29);
						lw.channel = i[2:0];
						lw.level   = (neg && lv != 0) ? -$signed({1'b0, lv}) : $signed({1'b0, lv});
						lw.last    = (i == n - 1);
						expected_levels.push_back(lw);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offer one word, with a random gap first unless the stretch is steady.
	task automatic send_word(input alloc_word_t wd);
		logic rdy;
		if (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= wd.command;
		s_tdata  <= {2'b00, wd.wrench, wd.value, wd.thr, wd.row};
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy)
				break;
		end
		words_sent++;
		predict_word(wd);
	endtask

	// Stop offering and let the block run dry before touching its registers.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read back of the same register.
	task automatic write_register(input tfa_pkg::tfa_reg_t idx, input logic [31:0] value);
		logic [31:0] want;
		logic [31:0] got;
		case (idx)
			tfa_pkg::REG_THRUSTER_COUNT: begin
				cfg_count = value[3:0];
				want = {28'd0, value[3:0]};
			end
			tfa_pkg::REG_DIRECT_MODE: begin
				cfg_direct = value[0];
				want = {31'd0, value[0]};
			end
			tfa_pkg::REG_INV_FORCE: begin
				cfg_inv_force = value[23:0];
				want = {8'd0, value[23:0]};
			end
			default: begin
				cfg_inv_moment = value[23:0];
				want = {8'd0, value[23:0]};
			end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
		if (got !== want)
			report_mismatch($sformatf("register %s read %h, written %h", idx.name(), got, want));
	endtask

	task automatic configure(input logic [31:0] count, input logic [31:0] direct,
			input logic [31:0] inv_force, input logic [31:0] inv_moment);
		write_register(tfa_pkg::REG_THRUSTER_COUNT, count);
		write_register(tfa_pkg::REG_DIRECT_MODE, direct);
		write_register(tfa_pkg::REG_INV_FORCE, inv_force);
		write_register(tfa_pkg::REG_INV_MOMENT, inv_moment);
	endtask

	// With no thrusters active an allocate yields nothing; command 3 is dropped too.
	task automatic test_no_thrusters();
		send_word(allocate_word({6{24'h7fffff}}));
		send_word(load_word(CMD_UNKNOWN, 3'd7, 3'd7, 24'hffffff));
		wait_idle();
	endtask

	// Coefficient extremes, a negative scale, ignored rows, then three two-thruster allocates.
	task automatic test_coefficient_loads();
		logic [23:0] row0 [tfa_pkg::WRENCH_DIM];
		row0 = '{24'h7fffff, 24'h800000, 24'h100000, 24'hf00000, 24'h000000, 24'h000001};
		for (int j = 0; j < tfa_pkg::WRENCH_DIM; j++)
			send_word(load_word(tfa_pkg::CMD_LOAD_COEF, j[2:0], 3'd0, row0[j]));
		send_word(load_word(tfa_pkg::CMD_LOAD_SCALE, 3'd0, 3'd0, 24'h010000));
		for (int j = 0; j < tfa_pkg::WRENCH_DIM; j++)
			send_word(load_word(tfa_pkg::CMD_LOAD_COEF, j[2:0], 3'd1, spread_value()));
		send_word(load_word(tfa_pkg::CMD_LOAD_SCALE, 3'd0, 3'd1, 24'h800000));
		// Rows past the wrench must not spill into the next thruster.
		send_word(load_word(tfa_pkg::CMD_LOAD_COEF, 3'd6, 3'd0, 24'h7fffff));
		send_word(load_word(tfa_pkg::CMD_LOAD_COEF, 3'd7, 3'd0, 24'h800000));
		wait_idle();
		write_register(tfa_pkg::REG_THRUSTER_COUNT, 32'd2);
		send_word(allocate_word({6{24'h7fffff}}));
		send_word(allocate_word({6{24'h800000}}));
		send_word(allocate_word({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd256}));
		wait_idle();
	endtask

	// Every coefficient and scale gets a value, so later allocates read only written entries.
	task automatic fill_stores();
		logic [23:0] v;
		for (int t = 0; t < tfa_pkg::MAX_THRUSTERS_DEF; t++) begin
			for (int j = 0; j < tfa_pkg::WRENCH_DIM; j++)
				send_word(load_word(tfa_pkg::CMD_LOAD_COEF, j[2:0], t[2:0], spread_value()));
			v = spread_value();
			send_word(load_word(tfa_pkg::CMD_LOAD_SCALE, 3'd0, t[2:0], {1'b0, v[22:0]}));
		end
		wait_idle();
	endtask

	// Direct mode with the limit extremes, zero limit among them.
	task automatic test_direct_mode();
		configure(32'hfffffff3, 32'hfffffffe | 32'd1, 32'h00ffffff, 32'd0);
		send_word(allocate_word({{3{24'h800000}}, {3{24'h7fffff}}}));
		send_word(allocate_word({24'h000001, 24'hffffff, 24'h000100,
			24'hffff00, 24'h000000, 24'h7fffff}));
		wait_idle();
		configure(32'd5, 32'd1, 32'h00010000, 32'h00123456);
		for (int k = 0; k < 1; k++)
			send_word(allocate_word({spread_value(), spread_value(), spread_value(),
				spread_value(), spread_value(), spread_value()}));
		wait_idle();
	endtask

	function automatic alloc_word_t random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return allocate_word({spread_value(), spread_value(), spread_value(),
				spread_value(), spread_value(), spread_value()});
		else if (pick < 82)
			return load_word(tfa_pkg::CMD_LOAD_COEF, 3'($urandom), 3'($urandom),
				spread_value());
		else if (pick < 96)
			return load_word(tfa_pkg::CMD_LOAD_SCALE, 3'($urandom), 3'($urandom),
				spread_value());
		return load_word(CMD_UNKNOWN, 3'($urandom), 3'($urandom), 24'($urandom));
	endfunction

	task automatic test_random_phase(input int items, input logic [31:0] count,
			input logic [31:0] direct, input logic [31:0] inv_force,
			input logic [31:0] inv_moment);
		configure(count, direct, inv_force, inv_moment);
		for (int k = 0; k < items; k++)
			send_word(random_word());
		wait_idle();
	endtask

	// The receiver stalls for a long stretch while allocates keep coming.
	task automatic test_backpressure();
		configure(32'd8, 32'd0, 32'h00010000, 32'h00010000);
		steady   = 1'b1;
		hold_off = 300;
		for (int k = 0; k < 25; k++)
			send_word(allocate_word({spread_value(), spread_value(), spread_value(),
				spread_value(), spread_value(), spread_value()}));
		wait_idle();
		steady = 1'b0;
	endtask

	// Output side: random ready, hold-off window, and the check of every word.
	initial begin : receiver
		logic        v;
		logic        r;
		logic [23:0] d;
		logic        l;
		level_word_t want;
		forever begin
			@(negedge clk);
			v = m_tvalid;
			r = m_tready;
			d = m_tdata;
			l = m_tlast;
			@(posedge clk);
			if (v && r) begin
				if (expected_levels.size() == 0) begin
					report_mismatch($sformatf("unexpected word: channel %0d level %0d",
						d[2:0], $signed(d[18:3])));
				end else begin
					want = expected_levels.pop_front();
					if (d[2:0] !== want.channel)
						report_mismatch($sformatf("channel %0d, expected %0d",
							d[2:0], want.channel));
					if ($signed(d[18:3]) !== want.level)
						report_mismatch($sformatf("channel %0d level %0d, expected %0d",
							want.channel, $signed(d[18:3]), want.level));
					if (l !== want.last)
						report_mismatch($sformatf("channel %0d tlast %b, expected %b",
							want.channel, l, want.last));
					levels_checked++;
				end
			end
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Ends the run when neither side nor the register port has moved for too long.
	initial begin : watchdog
		logic busy;
		int   quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			busy = (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel;
			@(posedge clk);
			quiet = busy ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout with %0d words still expected", expected_levels.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		errors         = 0;
		words_sent     = 0;
		levels_checked = 0;
		reg_writes     = 0;
		hold_off       = 0;
		steady         = 1'b0;
		cfg_count      = 4'd0;
		cfg_direct     = 1'b0;
		cfg_inv_force  = 24'd65536;
		cfg_inv_moment = 24'd65536;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_thrusters();
		test_coefficient_loads();
		fill_stores();
		test_direct_mode();
		test_random_phase(30, 32'd8, 32'd0, 32'h00010000, 32'h00010000);
		test_random_phase(20, 32'd3, 32'd0, 32'h00ffffff, 32'd0);
		test_random_phase(15, 32'd0, 32'd0, 32'h00000001, 32'h00ffffff);
		test_random_phase(20, 32'd1, 32'd1, $urandom, $urandom);
		steady = 1'b1;
		test_random_phase(20, 32'd15, 32'd0, 32'h00010000, 32'h00010000);
		steady = 1'b0;
		test_random_phase(20, 32'd1, 32'd0, $urandom, $urandom);
		test_backpressure();

		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_levels.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				expected_levels.size()));
		$display("Sent %0d input words and checked %0d output words over %0d register writes.",
			words_sent, levels_checked, reg_writes);
		$display("Covered load, allocate, direct mode, limit extremes and a long output stall.");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
